@@ rtl/category_filtered_knn_search_assert.svh @@
`ifndef CATEGORY_FILTERED_KNN_SEARCH_ASSERT_SVH
`define CATEGORY_FILTERED_KNN_SEARCH_ASSERT_SVH
`ifndef ASSERT_OFF
`define CFK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: label");
`define CFK_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m: label");
`else
`define CFK_ASSERT(label, clk, rst_n, prop)
`define CFK_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/cfk_pkg.sv @@
package cfk_pkg;
  localparam int ENTRIES = 1024;
  localparam int FEATURES = 5;
  localparam int MAX_NEIGHBOURS = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int FEAT_W = 16;
  localparam int DIST_W = 35;
  localparam int K_W = $clog2(MAX_NEIGHBOURS + 1);
  localparam int KI_W = $clog2(MAX_NEIGHBOURS);
  localparam int FI_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam int IN_W = 2 + 4 + 11 + 5 + 5 * FEAT_W;
  localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
  typedef logic [FEATURES*FEAT_W-1:0] vec_t;
endpackage

@@ rtl/category_filtered_knn_search.sv @@
// category_filtered_knn_search
// Input stream in_*: one request per item; tdata holds, from bit 0 up: mode(2),
// category(4), exclude_index(11), neighbours_wanted(5), feature_0..feature_4
// (16 each). Mode 0 appends an entry, mode 1 queries, mode 2 clears the store.
// Output stream out_*: tdata holds neighbour_index(10); tlast marks the final
// neighbour of a query. A query emits up to k indices in ascending distance.
// Append and clear complete as they are accepted. A query walks every stored entry
// once through one distance unit: per entry a read, one feature difference squared
// and accumulated per cycle (skipped if the entry is filtered out), and a compare;
// then an insertion pass over up to MAX_NEIGHBOURS list places for entries that
// make the list; then the results. in_tready is low while a request is in work.
// Reset (rst_n low, synchronous) empties the store and idles the sequencer;
// stored vectors are left as they were. A stall on out_tready holds the current
// result until taken; no results are lost.
module category_filtered_knn_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // mode, category, exclude_index, neighbours_wanted, feature_0..feature_4
  input  logic [cfk_pkg::IN_BYTES_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // neighbour_index
  output logic [15:0]                   out_tdata,
  output logic                          out_tlast
);
  import cfk_pkg::*;
`include "category_filtered_knn_search_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [1:0]        mode;
  logic [3:0]        cat_in;
  logic signed [10:0] excl_in;
  logic [4:0]        k_in;
  vec_t              vec_in;
  assign mode    = in_tdata[1:0];
  assign cat_in  = in_tdata[5:2];
  assign excl_in = in_tdata[16:6];
  assign k_in    = in_tdata[21:17];
  assign vec_in  = in_tdata[22 +: FEATURES*FEAT_W];

  vec_t feat_mem [ENTRIES];
  logic [3:0] cat_mem [ENTRIES];
  vec_t rd_vec_r;
  logic [3:0] rd_cat_r;

  logic [DIST_W-1:0] best_d [MAX_NEIGHBOURS];
  logic [IDX_W-1:0]  best_i [MAX_NEIGHBOURS];

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  scan_r;
  logic [FI_W-1:0]   fidx_r;
  logic [DIST_W-1:0] acc_r;
  logic [K_W-1:0]    n_r, k_r;
  logic [KI_W-1:0]   j_r;
  logic [K_W-1:0]    oi_r;
  vec_t              q_r;
  logic [3:0]        qcat_r;
  logic              excl_en_r;
  logic [IDX_W:0]    excl_r;

  logic accept;
  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready;

  // shared distance unit: one feature per cycle
  logic signed [FEAT_W-1:0]   fa, fb;
  logic signed [FEAT_W:0]     diff;
  logic signed [2*FEAT_W+1:0] sq_s;
  logic [2*FEAT_W+1:0]        sq;
  assign fa   = rd_vec_r[fidx_r*FEAT_W +: FEAT_W];
  assign fb   = q_r[fidx_r*FEAT_W +: FEAT_W];
  assign diff = {fa[FEAT_W-1], fa} - {fb[FEAT_W-1], fb};
  assign sq_s = diff * diff;
  assign sq   = $unsigned(sq_s);

  logic scan_idx_ok;
  assign scan_idx_ok = !(excl_en_r && excl_r == {1'b0, scan_r[IDX_W-1:0]});

  logic [K_W-1:0] k_sat;
  assign k_sat = (k_in > 5'(MAX_NEIGHBOURS)) ? K_W'(MAX_NEIGHBOURS) : K_W'(k_in);

  logic full_rej;
  assign full_rej = (n_r == k_r) && (acc_r >= best_d[KI_W'(n_r - 1'b1)]);

  logic shift_on;
  assign shift_on = (j_r != '0) && (best_d[j_r - 1'b1] > acc_r);

  always_ff @(posedge clk) begin
    if (accept && mode == MODE_APPEND && count_r < CNT_W'(ENTRIES)) begin
      feat_mem[count_r[IDX_W-1:0]] <= vec_in;
      cat_mem[count_r[IDX_W-1:0]]  <= cat_in;
    end
    rd_vec_r <= feat_mem[scan_r[IDX_W-1:0]];
    rd_cat_r <= cat_mem[scan_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_INS) begin
      if (shift_on) begin
        best_d[j_r] <= best_d[j_r - 1'b1];
        best_i[j_r] <= best_i[j_r - 1'b1];
      end else begin
        best_d[j_r] <= acc_r;
        best_i[j_r] <= scan_r[IDX_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && mode == MODE_QUERY && k_sat != '0 && count_r != '0)
                state_nxt = S_READ;
      S_READ: state_nxt = S_ACC;
      S_ACC:  if (rd_cat_r != qcat_r || !scan_idx_ok) state_nxt = S_CMP;
              else if (fidx_r == FI_W'(FEATURES - 1)) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_READ;
      S_INS:  if (!shift_on) state_nxt = S_READ;
      S_OUT:  if (out_tready && oi_r + 1'b1 == n_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_CMP) begin
      if (rd_cat_r == qcat_r && scan_idx_ok && !full_rej) state_nxt = S_INS;
      else if (scan_r + 1'b1 == count_r) state_nxt = (n_r != '0) ? S_OUT : S_IDLE;
    end
    if (state_r == S_INS && !shift_on)
      state_nxt = (scan_r + 1'b1 == count_r) ? S_OUT : S_READ;
  end

  logic cat_skip;
  assign cat_skip = (rd_cat_r != qcat_r) || !scan_idx_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && mode == MODE_CLEAR) count_r <= '0;
      if (accept && mode == MODE_APPEND && count_r < CNT_W'(ENTRIES))
        count_r <= count_r + 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        scan_r    <= '0;
        n_r       <= '0;
        k_r       <= k_sat;
        q_r       <= vec_in;
        qcat_r    <= cat_in;
        excl_en_r <= !excl_in[10];
        excl_r    <= excl_in[IDX_W:0];
        oi_r      <= '0;
      end
      S_READ: begin
        fidx_r <= '0;
        acc_r  <= '0;
      end
      S_ACC: if (!cat_skip) begin
        acc_r  <= acc_r + DIST_W'(sq);
        fidx_r <= fidx_r + 1'b1;
      end
      S_CMP: begin
        j_r <= (n_r < k_r) ? n_r[KI_W-1:0] : KI_W'(n_r - 1'b1);
        if (cat_skip || full_rej) scan_r <= scan_r + 1'b1;
      end
      S_INS: if (shift_on) j_r <= j_r - 1'b1;
        else begin
          if (n_r < k_r) n_r <= n_r + 1'b1;
          scan_r <= scan_r + 1'b1;
        end
      S_OUT: if (out_tready) oi_r <= oi_r + 1'b1;
      default: ;
    endcase
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = 16'(best_i[oi_r[KI_W-1:0]]);
  assign out_tlast  = (oi_r + 1'b1 == n_r);

  `CFK_ASSERT(a_cnt_max, clk, rst_n, count_r <= CNT_W'(ENTRIES))
  `CFK_ASSERT(a_n_le_k, clk, rst_n, n_r <= k_r || state_r == S_IDLE)
  `CFK_ASSERT(a_out_n, clk, rst_n, out_tvalid |-> (n_r != '0 && oi_r < n_r))
  `CFK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import cfk_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int STALL_FROM = 1500;
  localparam int STALL_LEN = 400;
  localparam int CALM_FROM = 1100;
  localparam int CALM_TO = 1250;
  localparam int SETTLE = 3000;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    bit hold;
    logic [4:0][FEAT_W-1:0] f;
    logic [4:0] k;
    logic [10:0] excl;
    logic [3:0] cat;
    logic [1:0] mode;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    bit last;
  } neighbour_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_BYTES_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [15:0] out_tdata;
  logic out_tlast;

  category_filtered_knn_search DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  request_t pending_requests[$];
  neighbour_t expected_neighbours[$];
  request_t current;

  logic [FEAT_W-1:0] feature_mem[ENTRIES][5];
  logic [3:0] category_mem[ENTRIES];
  int stored_count;

  int errors;
  int cycle;
  int quiet;
  int requests_taken;
  int queries_taken;
  int neighbours_seen;
  int shadow_count;
  int stall_left;
  bit stall_done;
  bit calm;

  assign calm = (requests_taken >= CALM_FROM) && (requests_taken < CALM_TO);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch @%0d: %s", cycle, what);
    errors++;
  endtask

  function automatic void predict_neighbours(input request_t r);
    longint best_dist[MAX_NEIGHBOURS];
    int best_idx[MAX_NEIGHBOURS];
    int kk;
    int n;
    int j;
    longint d;
    longint diff;
    neighbour_t e;
    n = 0;
    case (r.mode)
      MODE_CLEAR: stored_count = 0;
      MODE_APPEND: begin
        if (stored_count < ENTRIES) begin
          for (int f = 0; f < 5; f++) feature_mem[stored_count][f] = r.f[f];
          category_mem[stored_count] = r.cat;
          stored_count++;
        end
      end
      MODE_QUERY: begin
        kk = (r.k > MAX_NEIGHBOURS) ? MAX_NEIGHBOURS : int'(r.k);
        if (kk != 0) begin
          for (int i = 0; i < stored_count; i++) begin
            if (!r.excl[10] && int'(r.excl) == i) continue;
            if (category_mem[i] != r.cat) continue;
            d = 0;
            for (int f = 0; f < 5; f++) begin
              diff = longint'($signed(feature_mem[i][f])) - longint'($signed(r.f[f]));
              d += diff * diff;
            end
            if (n == kk && d >= best_dist[n-1]) continue;
            j = (n < kk) ? n : n - 1;
            while (j > 0 && best_dist[j-1] > d) begin
              best_dist[j] = best_dist[j-1];
              best_idx[j] = best_idx[j-1];
              j--;
            end
            best_dist[j] = d;
            best_idx[j] = i;
            if (n < kk) n++;
          end
          for (int i = 0; i < n; i++) begin
            e.idx = best_idx[i][IDX_W-1:0];
            e.last = (i + 1 == n);
            expected_neighbours = {expected_neighbours, e};
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_neighbours(current);
        requests_taken++;
        if (current.mode == MODE_QUERY) queries_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() > 0 &&
            !(pending_requests[0].hold && (expected_neighbours.size() != 0 || quiet < 40)) &&
            (calm || $urandom_range(99) >= 26)) begin
          current = pending_requests.pop_front();
          in_tdata <= IN_BYTES_W'({current.f, current.k, current.excl, current.cat,
                                   current.mode});
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    quiet <= (expected_neighbours.size() == 0 && !in_tvalid) ? quiet + 1 : 0;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // long receiver hold-off, started once results are flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_done && cycle >= STALL_FROM && out_tvalid) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    neighbour_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        neighbours_seen++;
        if (expected_neighbours.size() == 0) begin
          report_mismatch($sformatf("unexpected result index %0d", out_tdata));
        end else begin
          e = expected_neighbours.pop_front();
          if (out_tdata !== 16'(e.idx))
            report_mismatch($sformatf("index %0d, want %0d", out_tdata, e.idx));
          if (out_tlast !== e.last)
            report_mismatch($sformatf("tlast %0b, want %0b", out_tlast, e.last));
        end
      end
      if (stall_left != 0) out_tready <= 1'b0;
      else out_tready <= calm || ($urandom_range(99) >= 26);
    end
  end

  function automatic logic [4:0][FEAT_W-1:0] pick_vector(input bit narrow);
    logic [4:0][FEAT_W-1:0] v;
    for (int f = 0; f < 5; f++)
      v[f] = narrow ? FEAT_W'($urandom_range(8) - 4) : FEAT_W'($urandom);
    return v;
  endfunction

  function automatic void add_request(input logic [1:0] mode, input int cat, input int excl,
                                      input int k, input logic [4:0][FEAT_W-1:0] v,
                                      input bit hold);
    request_t r;
    r.mode = mode;
    r.cat = 4'(cat);
    r.excl = 11'(excl);
    r.k = 5'(k);
    r.f = v;
    r.hold = hold;
    pending_requests = {pending_requests, r};
    if (mode == MODE_CLEAR) shadow_count = 0;
    else if (mode == MODE_APPEND && shadow_count < ENTRIES) shadow_count++;
  endfunction

  function automatic int pick_category();
    return ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(15);
  endfunction

  initial begin
    logic [4:0][FEAT_W-1:0] hi, lo, mid;
    int groups;
    int n;
    int ex;
    bit narrow;
    hi = {5{16'sh7FFF}};
    lo = {5{16'sh8000}};
    mid = '0;
    errors = 0;
    cycle = 0;
    quiet = 0;
    requests_taken = 0;
    queries_taken = 0;
    neighbours_seen = 0;
    stored_count = 0;
    shadow_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;

    // directed: extremes, ties, k limits, exclusion, unused mode, empty store
    add_request(MODE_QUERY, 0, -1, 16, mid, 0);
    add_request(MODE_APPEND, 0, 0, 0, lo, 0);
    add_request(MODE_APPEND, 15, 1023, 31, hi, 0);
    add_request(MODE_APPEND, 0, 0, 0, mid, 0);
    add_request(MODE_APPEND, 0, 0, 0, mid, 0);
    add_request(MODE_APPEND, 15, 0, 0, lo, 0);
    add_request(MODE_QUERY, 0, -1, 16, hi, 0);
    add_request(MODE_QUERY, 15, -1024, 31, hi, 0);
    add_request(MODE_QUERY, 0, 0, 17, mid, 0);
    add_request(MODE_QUERY, 0, 2, 2, mid, 0);
    add_request(MODE_QUERY, 0, 1023, 1, lo, 0);
    add_request(MODE_QUERY, 0, -1, 0, mid, 0);
    add_request(MODE_QUERY, 7, -1, 16, mid, 0);
    add_request(MODE_NONE, 15, -1, 31, hi, 0);
    add_request(MODE_QUERY, 0, 5, 16, mid, 1);
    add_request(MODE_CLEAR, 0, 0, 0, mid, 0);
    add_request(MODE_QUERY, 0, -1, 16, mid, 0);

    // fill past capacity
    for (int i = 0; i < ENTRIES + 3; i++)
      add_request(MODE_APPEND, $urandom_range(3), 0, 0, pick_vector(1'($urandom_range(1))), 0);
    add_request(MODE_QUERY, 1, -1, 16, pick_vector(0), 0);
    add_request(MODE_QUERY, $urandom_range(3), 1023, 31, pick_vector(1), 1);
    add_request(MODE_CLEAR, 0, 0, 0, mid, 0);

    groups = 0;
    while (pending_requests.size() < ENTRIES + 30 + 420) begin
      groups++;
      if ($urandom_range(2) == 0) add_request(MODE_CLEAR, 0, 0, 0, mid, $urandom_range(4) == 0);
      narrow = $urandom_range(2) == 0;
      n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++)
        add_request(MODE_APPEND, pick_category(), $urandom, $urandom, pick_vector(narrow), 0);
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(9))
          0, 1: ex = $urandom;
          2, 3, 4: ex = $urandom_range(shadow_count + 2);
          default: ex = -1;
        endcase
        add_request(MODE_QUERY, pick_category(), ex,
                    ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(20),
                    pick_vector(narrow), i == 0 && $urandom_range(4) == 0);
      end
      if ($urandom_range(9) == 0) add_request(MODE_NONE, $urandom, $urandom, $urandom,
                                              pick_vector(0), 0);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_tvalid || expected_neighbours.size() != 0);
    repeat (SETTLE) @(posedge clk);

    $display("run: %0d requests (%0d queries, %0d random groups), store filled past capacity",
             requests_taken, queries_taken, groups);
    $display("run: %0d neighbours checked with stalls on both sides", neighbours_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
